@@ sv/rcq_pkg.sv @@
`timescale 1ns / 1ps
package rcq_pkg;
	localparam int PW = 11;
	localparam int VW = 30;
	localparam logic [VW-1:0] NO_MARK = 30'h3f3f3f3f;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_LOAD  = 2'd0;
	localparam func_t FUNC_CHMIN = 2'd1;
	localparam func_t FUNC_QUERY = 2'd2;

	typedef logic [PW-1:0] pos_t;
	typedef logic [VW-1:0] val_t;

	function automatic val_t vmin(input val_t a, input val_t b);
		return (a < b) ? a : b;
	endfunction
endpackage

@@ sv/rcq_ram.sv @@
`timescale 1ns / 1ps
module rcq_ram #(
	parameter int W = 30,
	parameter int D = 4096
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sv/range_chmin_point_query_tree_core.sv @@
`timescale 1ns / 1ps
// one item at a time; a new item is taken only when the tree walker is idle
// load: walks the path from root to leaf, clearing each mark on the way and writing the value at the leaf
// query: at each internal level the mark is read and pushed into both children; at the leaf the value is output
// range-min: a partially covered node pushes its mark into both children, a covering node takes the value
// after reset and after each register write the mark memory is swept, all 4*MAX_POSITIONS entries
module range_chmin_point_query_tree_core
	import rcq_pkg::*;
#(
	parameter int MAX_POSITIONS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [10:0] position,
	input  logic [10:0] range_low,
	input  logic [10:0] range_high,
	input  logic [29:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [29:0] query_value
);
	localparam int DEPTH = 4 * MAX_POSITIONS;
	localparam int NW    = $clog2(DEPTH);
	localparam int SD    = $clog2(MAX_POSITIONS) + 3;
	localparam int SIW   = $clog2(SD);
	localparam int SPW   = $clog2(SD + 1);
	localparam int N_RST = (MAX_POSITIONS < 1024) ? MAX_POSITIONS : 1024;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLEAR = 4'd1;
	localparam logic [3:0] ST_POP   = 4'd2;
	localparam logic [3:0] ST_C_WR  = 4'd3;
	localparam logic [3:0] ST_P_C1  = 4'd4;
	localparam logic [3:0] ST_P_W1  = 4'd5;
	localparam logic [3:0] ST_P_W2  = 4'd6;
	localparam logic [3:0] ST_Q_STEP = 4'd7;
	localparam logic [3:0] ST_Q_OUT = 4'd8;
	localparam logic [3:0] ST_L_STEP = 4'd9;

	logic [3:0]    state_q;
	logic [NW-1:0] clr_q;
	pos_t          n_q;
	func_t         func_q;
	pos_t          pos_q, l_q, r_q;
	val_t          v_q, b_q;
	logic [NW-1:0] cur_node_q;
	pos_t          cur_lo_q, cur_hi_q;
	logic [NW-1:0] stk_node_q [SD];
	pos_t          stk_lo_q [SD];
	pos_t          stk_hi_q [SD];
	logic [SPW-1:0] sp_q;
	logic          out_valid_q;
	val_t          query_value_q;

	logic          a_we, a_re, b_we, b_re;
	logic [NW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
	val_t          a_wdata, b_wdata, a_rdata, b_rdata;

	rcq_ram #(.W(VW), .D(DEPTH)) u_mark (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.re(a_re), .raddr(a_raddr), .rdata(a_rdata)
	);
	rcq_ram #(.W(VW), .D(DEPTH)) u_minv (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.re(b_re), .raddr(b_raddr), .rdata(b_rdata)
	);

	// accept side
	logic  accept, pos_ok, rng_ok;
	pos_t  lc, hc;
	val_t  vsat;
	pos_t  cfg_n;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign query_value = query_value_q;

	assign pos_ok = (position != '0) && (position <= n_q);
	assign lc     = (range_low == '0) ? pos_t'(1) : range_low;
	assign hc     = (range_high > n_q) ? n_q : range_high;
	assign rng_ok = (lc <= hc);
	assign vsat   = (value > NO_MARK) ? NO_MARK : value;
	assign cfg_n  = (cfg_data == '0) ? pos_t'(1) :
		((32'(cfg_data) > 32'(MAX_POSITIONS)) ? pos_t'(MAX_POSITIONS) : cfg_data);

	// stack top and walk helpers
	logic [SIW-1:0] top_idx, nxt_idx;
	logic [NW-1:0]  t_node, t_left, t_right;
	pos_t           t_lo, t_hi, t_mid;
	logic           t_cov, has_l, has_r;
	logic [NW-1:0]  c_left, c_right;
	pos_t           c_mid;

	assign top_idx = SIW'(sp_q - SPW'(1));
	assign nxt_idx = SIW'(sp_q);
	assign t_node  = stk_node_q[top_idx];
	assign t_lo    = stk_lo_q[top_idx];
	assign t_hi    = stk_hi_q[top_idx];
	assign t_mid   = PW'(({1'b0, t_lo} + {1'b0, t_hi}) >> 1);
	assign t_left  = {t_node[NW-2:0], 1'b0};
	assign t_right = {t_node[NW-2:0], 1'b1};
	assign t_cov   = (l_q <= t_lo) && (t_hi <= r_q);
	assign has_l   = (l_q <= t_mid);
	assign has_r   = (r_q > t_mid);

	assign c_mid   = PW'(({1'b0, cur_lo_q} + {1'b0, cur_hi_q}) >> 1);
	assign c_left  = {cur_node_q[NW-2:0], 1'b0};
	assign c_right = {cur_node_q[NW-2:0], 1'b1};

	always_comb begin
		a_we = 1'b0; a_waddr = cur_node_q; a_wdata = NO_MARK;
		a_re = 1'b0; a_raddr = cur_node_q;
		b_we = 1'b0; b_waddr = cur_node_q; b_wdata = v_q;
		b_re = 1'b0; b_raddr = cur_node_q;
		case (state_q)
			ST_CLEAR: begin
				a_we = 1'b1;
				a_waddr = clr_q;
			end
			ST_POP: begin
				if (sp_q != '0) begin
					a_re = 1'b1;
					a_raddr = t_node;
					b_re = t_cov;
					b_raddr = t_node;
				end
			end
			ST_C_WR: begin
				a_we = 1'b1;
				a_wdata = vmin(a_rdata, v_q);
				b_we = 1'b1;
				b_wdata = vmin(b_rdata, v_q);
			end
			ST_P_C1: begin
				a_re = 1'b1; a_raddr = c_left;
				b_re = 1'b1; b_raddr = c_left;
			end
			ST_P_W1: begin
				a_we = 1'b1; a_waddr = c_left; a_wdata = vmin(a_rdata, b_q);
				b_we = 1'b1; b_waddr = c_left; b_wdata = vmin(b_rdata, b_q);
				a_re = 1'b1; a_raddr = c_right;
				b_re = 1'b1; b_raddr = c_right;
			end
			ST_P_W2: begin
				a_we = 1'b1; a_waddr = c_right; a_wdata = vmin(a_rdata, b_q);
				b_we = 1'b1; b_waddr = c_right; b_wdata = vmin(b_rdata, b_q);
			end
			ST_Q_STEP: begin
				if (cur_lo_q == cur_hi_q) begin
					b_re = 1'b1;
				end else begin
					a_re = 1'b1;
				end
			end
			ST_L_STEP: begin
				a_we = 1'b1;
				b_we = (cur_lo_q == cur_hi_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			n_q         <= pos_t'(N_RST);
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the result state reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != ST_Q_OUT || cfg_write)) begin
				out_valid_q <= 1'b0;
			end
			// tree shape changes, so the marks are swept again
			if (cfg_write) begin
				n_q     <= cfg_n;
				clr_q   <= '0;
				state_q <= ST_CLEAR;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (accept) begin
							func_q     <= func;
							pos_q      <= position;
							l_q        <= lc;
							r_q        <= hc;
							v_q        <= vsat;
							cur_node_q <= NW'(1);
							cur_lo_q   <= pos_t'(1);
							cur_hi_q   <= n_q;
							case (func)
								FUNC_LOAD:  if (pos_ok) state_q <= ST_L_STEP;
								FUNC_QUERY: if (pos_ok) state_q <= ST_Q_STEP;
								FUNC_CHMIN: begin
									if (rng_ok) begin
										stk_node_q[0] <= NW'(1);
										stk_lo_q[0]   <= pos_t'(1);
										stk_hi_q[0]   <= n_q;
										sp_q          <= SPW'(1);
										state_q       <= ST_POP;
									end
								end
								default: begin
								end
							endcase
						end
					end
					ST_CLEAR: begin
						clr_q <= clr_q + NW'(1);
						if (clr_q == NW'(DEPTH - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_POP: begin
						if (sp_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							cur_node_q <= t_node;
							cur_lo_q   <= t_lo;
							cur_hi_q   <= t_hi;
							if (t_cov) begin
								sp_q    <= sp_q - SPW'(1);
								state_q <= ST_C_WR;
							end else begin
								// left child goes on top so it is visited first
								if (has_l && has_r) begin
									stk_node_q[top_idx] <= t_right;
									stk_lo_q[top_idx]   <= t_mid + pos_t'(1);
									stk_hi_q[top_idx]   <= t_hi;
									stk_node_q[nxt_idx] <= t_left;
									stk_lo_q[nxt_idx]   <= t_lo;
									stk_hi_q[nxt_idx]   <= t_mid;
									sp_q                <= sp_q + SPW'(1);
								end else if (has_l) begin
									stk_node_q[top_idx] <= t_left;
									stk_lo_q[top_idx]   <= t_lo;
									stk_hi_q[top_idx]   <= t_mid;
								end else begin
									stk_node_q[top_idx] <= t_right;
									stk_lo_q[top_idx]   <= t_mid + pos_t'(1);
									stk_hi_q[top_idx]   <= t_hi;
								end
								state_q <= ST_P_C1;
							end
						end
					end
					ST_C_WR: state_q <= ST_POP;
					ST_P_C1: begin
						b_q     <= a_rdata;
						state_q <= ST_P_W1;
					end
					ST_P_W1: state_q <= ST_P_W2;
					ST_P_W2: begin
						if (func_q == FUNC_CHMIN) begin
							state_q <= ST_POP;
						end else begin
							if (pos_q <= c_mid) begin
								cur_node_q <= c_left;
								cur_hi_q   <= c_mid;
							end else begin
								cur_node_q <= c_right;
								cur_lo_q   <= c_mid + pos_t'(1);
							end
							state_q <= ST_Q_STEP;
						end
					end
					ST_Q_STEP: begin
						state_q <= (cur_lo_q == cur_hi_q) ? ST_Q_OUT : ST_P_C1;
					end
					ST_Q_OUT: begin
						if (!out_valid_q || !out_stall) begin
							out_valid_q   <= 1'b1;
							query_value_q <= b_rdata;
							state_q       <= ST_IDLE;
						end
					end
					ST_L_STEP: begin
						if (cur_lo_q == cur_hi_q) begin
							state_q <= ST_IDLE;
						end else if (pos_q <= c_mid) begin
							cur_node_q <= c_left;
							cur_hi_q   <= c_mid;
						end else begin
							cur_node_q <= c_right;
							cur_lo_q   <= c_mid + pos_t'(1);
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end
endmodule

@@ sim/tb_range_chmin_point_query_tree_core.sv @@
`timescale 1ns / 1ps
module tb_range_chmin_point_query_tree_core;
	import rcq_pkg::*;

	localparam int MAXP = 1024;
	localparam int SLOTS = 4 * MAXP;
	localparam int SETTLE = 800;
	localparam longint CYCLE_LIMIT = 3000000;

	// tracks the lazy-min tree and the queue of query answers still owed
	class tree_scoreboard;
		val_t node_min[SLOTS];
		val_t mark[SLOTS];
		int unsigned npos;
		val_t answers[$];
		int fails;

		function void clear(int unsigned n);
			for (int i = 0; i < SLOTS; i++) begin
				node_min[i] = '0;
				mark[i] = NO_MARK;
			end
			npos = n;
		endfunction

		function val_t lower(val_t a, val_t b);
			return (a < b) ? a : b;
		endfunction

		function void push_down(int unsigned u);
			for (int unsigned c = 2 * u; c <= 2 * u + 1; c++) begin
				node_min[c] = lower(node_min[c], mark[u]);
				mark[c] = lower(mark[c], mark[u]);
			end
		endfunction

		function void chmin(int unsigned u, int unsigned lo, int unsigned hi,
				int unsigned l, int unsigned r, val_t v);
			int unsigned mid;
			if (l <= lo && hi <= r) begin
				node_min[u] = lower(node_min[u], v);
				mark[u] = lower(mark[u], v);
				return;
			end
			push_down(u);
			mid = (lo + hi) >> 1;
			if (l <= mid) chmin(2 * u, lo, mid, l, r, v);
			if (r > mid) chmin(2 * u + 1, mid + 1, hi, l, r, v);
			node_min[u] = lower(node_min[2 * u], node_min[2 * u + 1]);
		endfunction

		// marks on the path are dropped, not pushed
		function void load(int unsigned u, int unsigned lo, int unsigned hi,
				int unsigned p, val_t v);
			int unsigned mid;
			mark[u] = NO_MARK;
			if (lo == hi) begin
				node_min[u] = v;
				return;
			end
			mid = (lo + hi) >> 1;
			if (p <= mid) load(2 * u, lo, mid, p, v);
			else load(2 * u + 1, mid + 1, hi, p, v);
			node_min[u] = lower(node_min[2 * u], node_min[2 * u + 1]);
		endfunction

		function val_t leaf_value(int unsigned u, int unsigned lo, int unsigned hi,
				int unsigned p);
			int unsigned mid;
			if (lo == hi) return node_min[u];
			push_down(u);
			mid = (lo + hi) >> 1;
			if (p <= mid) return leaf_value(2 * u, lo, mid, p);
			return leaf_value(2 * u + 1, mid + 1, hi, p);
		endfunction

		function void note_item(func_t f, pos_t p, pos_t l, pos_t h, val_t v);
			int unsigned lo;
			int unsigned hi;
			val_t sv;
			sv = (v > NO_MARK) ? NO_MARK : v;
			lo = l;
			hi = h;
			case (f)
				FUNC_LOAD: begin
					if (p >= 1 && p <= npos) load(1, 1, npos, p, sv);
				end
				FUNC_CHMIN: begin
					if (lo < 1) lo = 1;
					if (hi > npos) hi = npos;
					if (lo <= hi) chmin(1, 1, npos, lo, hi, sv);
				end
				FUNC_QUERY: begin
					if (p >= 1 && p <= npos) answers.push_back(leaf_value(1, 1, npos, p));
				end
				default: ;
			endcase
		endfunction

		function void check_result(val_t got);
			val_t want;
			if (answers.size() == 0) begin
				$error("query_value: unexpected transfer, got %0d", got);
				fails++;
				return;
			end
			want = answers.pop_front();
			if (got !== want) begin
				$error("query_value expected %0d actual %0d", want, got);
				fails++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write = 0;
	logic [10:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	func_t func = FUNC_LOAD;
	pos_t position = '0;
	pos_t range_low = '0;
	pos_t range_high = '0;
	val_t value = '0;
	logic out_valid;
	logic out_stall = 0;
	val_t query_value;

	tree_scoreboard sb = new();
	int unsigned npos;
	bit loaded[MAXP + 1];
	int unsigned loaded_list[$];
	int sent;
	bit hold_done;
	longint cycles;

	range_chmin_point_query_tree_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .position(position),
		.range_low(range_low), .range_high(range_high), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .query_value(query_value)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// predict on every accepted transfer, check every delivered result
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_item(func, position, range_low, range_high, value);
			if (out_valid && !out_stall) sb.check_result(query_value);
		end
	end

	// receiver: random stall per result, one long hold-off mid run
	initial begin : receiver
		int wait_left;
		wait_left = $urandom_range(0, 14);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) wait_left = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0 && wait_left > 0 && !hold_done) wait_left = 0;
			if (!hold_done && sent >= 120) begin
				hold_done = 1;
				wait_left = 700;
			end
			if (wait_left > 0) begin
				out_stall <= 1;
				wait_left--;
			end else begin
				out_stall <= 0;
			end
		end
	end

	task automatic send(func_t f, int p, int l, int h, val_t v);
		int gap;
		gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		func <= f;
		position <= pos_t'(p);
		range_low <= pos_t'(l);
		range_high <= pos_t'(h);
		value <= v;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sent++;
		if (f == FUNC_LOAD && p >= 1 && p <= npos && !loaded[p]) begin
			loaded[p] = 1;
			loaded_list.push_back(p);
		end
	endtask

	function automatic val_t rand_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return NO_MARK;
			default: return val_t'($urandom_range(0, 32'h3fffffff));
		endcase
	endfunction

	task automatic drain();
		in_valid <= 0;
		wait (sb.answers.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(int unsigned raw);
		drain();
		cfg_write <= 1;
		cfg_data <= 11'(raw);
		@(posedge clk);
		cfg_write <= 0;
		npos = (raw == 0) ? 1 : (raw > MAXP ? MAXP : raw);
		sb.clear(npos);
		for (int i = 0; i <= MAXP; i++) loaded[i] = 0;
		loaded_list.delete();
	endtask

	task automatic random_phase(int count);
		int p;
		int l;
		int h;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2: send(FUNC_LOAD, $urandom_range(1, npos), 0, 0, rand_value());
				3, 4, 5, 6, 7, 8, 9, 10: begin
					l = $urandom_range(1, npos);
					h = $urandom_range(l, npos);
					if ($urandom_range(0, 2) == 0) h = l + $urandom_range(0, 3);
					if (h > npos) h = npos;
					send(FUNC_CHMIN, $urandom_range(0, 2047), l, h, rand_value());
				end
				11, 12, 13, 14, 15, 16: begin
					if (loaded_list.size() > 0) begin
						p = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
						send(FUNC_QUERY, p, $urandom_range(0, 2047), $urandom_range(0, 2047),
							rand_value());
					end
				end
				17: send(FUNC_CHMIN, 0, $urandom_range(0, 2047), $urandom_range(0, 2047),
					val_t'($urandom_range(0, 32'h3fffffff)));
				18: send(2'd3, $urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 2047), val_t'($urandom_range(0, 32'h3fffffff)));
				default: send($urandom_range(0, 1) ? FUNC_LOAD : FUNC_QUERY,
					$urandom_range(0, 1) ? 0 : $urandom_range(npos + 1, 2047), 0, 0, rand_value());
			endcase
		end
	endtask

	task automatic fill_all();
		for (int p = 1; p <= npos; p++) send(FUNC_LOAD, p, 0, 0, rand_value());
	endtask

	initial begin
		cycles = 0;
		sent = 0;
		hold_done = 0;
		npos = MAXP;
		sb.clear(MAXP);
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// field extremes, saturation, ignored items, marks lost on load
		send(FUNC_LOAD, 1, 0, 0, '0);
		send(FUNC_LOAD, 1024, 0, 0, '1);
		send(FUNC_LOAD, 512, 0, 0, NO_MARK);
		send(FUNC_LOAD, 513, 0, 0, 30'd1);
		send(FUNC_QUERY, 1024, 0, 0, '0);
		send(FUNC_QUERY, 512, 0, 0, '0);
		send(FUNC_CHMIN, 0, 0, 2047, 30'h3f3f3f40);
		send(FUNC_QUERY, 1024, 0, 0, '0);
		send(FUNC_CHMIN, 0, 9, 3, '0);
		send(FUNC_CHMIN, 0, 500, 1024, 30'd77);
		send(FUNC_QUERY, 513, 0, 0, '0);
		send(FUNC_QUERY, 512, 0, 0, '0);
		send(FUNC_LOAD, 1000, 0, 0, 30'd5000);
		send(FUNC_QUERY, 1024, 0, 0, '0);
		send(FUNC_QUERY, 1000, 0, 0, '0);
		send(FUNC_LOAD, 0, 0, 0, 30'd3);
		send(FUNC_LOAD, 1025, 0, 0, 30'd3);
		send(FUNC_QUERY, 0, 0, 0, '0);
		send(FUNC_QUERY, 2047, 2047, 2047, '1);
		send(2'd3, 2047, 2047, 2047, '1);
		send(FUNC_QUERY, 1, 0, 0, '0);
		for (int i = 0; i < 60; i++) send(FUNC_LOAD, $urandom_range(1, 1024), 0, 0, rand_value());
		random_phase(260);

		set_count(0);
		fill_all();
		random_phase(40);
		set_count(2);
		fill_all();
		random_phase(80);
		set_count(2047);
		for (int i = 0; i < 40; i++) send(FUNC_LOAD, $urandom_range(1, 1024), 0, 0, rand_value());
		random_phase(180);
		set_count(13);
		fill_all();
		random_phase(180);
		set_count(100);
		fill_all();
		random_phase(200);
		set_count(1);
		fill_all();
		random_phase(40);

		drain();
		if (sb.fails == 0 && sb.answers.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
